// ===== design/bf3_pkg.sv =====
// ----------------------------------------------------------------------------
// bf3_pkg: shared constants and types for the 3x3 RGB box filter
// Sizes, register indexes, the divide-by-nine reciprocal and pipeline structs.
// ----------------------------------------------------------------------------
package bf3_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int MIN_DIM    = 3;

  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int DIM_W  = 12;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SUM_W  = 12;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  // floor(s / 9) == (s * 7282) >> 16 for every nine-pixel sum s.
  localparam int RECIP_W   = 13;
  localparam int DIV_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(7282);
  localparam int PROD_W = SUM_W + RECIP_W;

  localparam int NUM_RES = 3;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last_col;
    logic             last_row;
  } bf3_item_t;

  typedef struct packed {
    logic [2:0][SUM_W-1:0] sum;
    logic [PIX_W-1:0]      center;
    logic [PIX_W-1:0]      right_mid;
  } bf3_view_t;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
  } bf3_result_t;

endpackage

// ===== design/bf3_pix_if.sv =====
// ----------------------------------------------------------------------------
// bf3_pix_if: input pixel channel
// Valid/ready channel carrying one RGB pixel per word.
// ----------------------------------------------------------------------------
interface bf3_pix_if;
  logic                     valid;
  logic                     ready;
  logic [bf3_pkg::CH_W-1:0] red_in;
  logic [bf3_pkg::CH_W-1:0] green_in;
  logic [bf3_pkg::CH_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                output ready);
endinterface

// ===== design/bf3_res_if.sv =====
// ----------------------------------------------------------------------------
// bf3_res_if: result pixel channel
// Valid/ready channel carrying one filtered pixel with its position per word.
// ----------------------------------------------------------------------------
interface bf3_res_if;
  logic                      valid;
  logic                      ready;
  logic [bf3_pkg::CH_W-1:0]  red_out;
  logic [bf3_pkg::CH_W-1:0]  green_out;
  logic [bf3_pkg::CH_W-1:0]  blue_out;
  logic [bf3_pkg::ROW_W-1:0] out_row;
  logic [bf3_pkg::COL_W-1:0] out_col;
  logic                      run_last;
  logic                      frame_done;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output out_row, output out_col, output run_last, output frame_done,
                  input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input out_row, input out_col, input run_last, input frame_done,
                output ready);
endinterface

// ===== design/bf3_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bf3_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface bf3_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bf3_pkg::CFG_IDX_W-1:0] index;
  logic [bf3_pkg::DIM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/bf3_ram.sv =====
// ----------------------------------------------------------------------------
// bf3_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/bf3_window.sv =====
// ----------------------------------------------------------------------------
// bf3_window: 3x3 pixel window and channel sums
// Shifts a new column into the window and presents the sums of the window
// that results from the shift, with its center and middle right pixels.
// ----------------------------------------------------------------------------
module bf3_window (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      shift,
  input  logic [bf3_pkg::PIX_W-1:0] older,
  input  logic [bf3_pkg::PIX_W-1:0] newer,
  input  logic [bf3_pkg::PIX_W-1:0] px,
  output bf3_pkg::bf3_view_t        view
);

  logic [bf3_pkg::PIX_W-1:0] win      [9];
  logic [bf3_pkg::PIX_W-1:0] win_next [9];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[k*3]     = win[k*3+1];
      win_next[k*3 + 1] = win[k*3+2];
    end
    win_next[2] = older;
    win_next[5] = newer;
    win_next[8] = px;
  end

  always_comb begin
    logic [bf3_pkg::SUM_W-1:0] row_sum [3];
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 3; k++) begin
        row_sum[k] = bf3_pkg::SUM_W'(win_next[k*3][ch*bf3_pkg::CH_W +: bf3_pkg::CH_W])
                   + bf3_pkg::SUM_W'(win_next[k*3+1][ch*bf3_pkg::CH_W +: bf3_pkg::CH_W])
                   + bf3_pkg::SUM_W'(win_next[k*3+2][ch*bf3_pkg::CH_W +: bf3_pkg::CH_W]);
      end
      view.sum[ch] = row_sum[0] + row_sum[1] + row_sum[2];
    end
    view.center    = win_next[4];
    view.right_mid = win_next[5];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (shift) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

endmodule

// ===== design/bf3_emit.sv =====
// ----------------------------------------------------------------------------
// bf3_emit: result emitter
// Holds the up to three results of one pixel and sends them in order,
// marking the last one of the group.
// ----------------------------------------------------------------------------
module bf3_emit (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             in_valid,
  input  logic [bf3_pkg::NUM_RES-1:0]                      in_mask,
  input  bf3_pkg::bf3_result_t [bf3_pkg::NUM_RES-1:0]      in_res,
  output logic                                             free,
  bf3_res_if.source                                        results
);

  logic [bf3_pkg::NUM_RES-1:0]                 mask;
  bf3_pkg::bf3_result_t [bf3_pkg::NUM_RES-1:0] res;
  logic [bf3_pkg::NUM_RES-1:0]                 low_bit;
  logic                                        only_one;
  logic                                        take;
  logic                                        load;
  bf3_pkg::bf3_result_t                        cur;

  assign low_bit  = mask & (~mask + bf3_pkg::NUM_RES'(1));
  assign only_one = (mask & (mask - bf3_pkg::NUM_RES'(1))) == '0;
  assign take     = results.valid && results.ready;
  assign free     = (mask == '0) || (take && only_one);
  assign load     = in_valid && free;

  always_comb begin
    cur = res[0];
    for (int i = bf3_pkg::NUM_RES - 1; i >= 0; i--) begin
      if (low_bit[i]) begin
        cur = res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= in_mask;
    end else if (take) begin
      mask <= mask & ~low_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= in_res;
    end
  end

  assign results.valid      = mask != '0;
  assign results.red_out    = cur.px[0 +: bf3_pkg::CH_W];
  assign results.green_out  = cur.px[bf3_pkg::CH_W +: bf3_pkg::CH_W];
  assign results.blue_out   = cur.px[2*bf3_pkg::CH_W +: bf3_pkg::CH_W];
  assign results.out_row    = cur.row;
  assign results.out_col    = cur.col;
  assign results.run_last   = only_one;
  assign results.frame_done = cur.done;

endmodule

// ===== design/rgb_box_filter_3x3.sv =====
// ----------------------------------------------------------------------------
// rgb_box_filter_3x3: streaming 3x3 box filter for RGB pixels
// Line stores in one RAM, a 3x3 window, a reciprocal divide by nine and an
// emitter that sends the up to three result words each pixel causes.
// ----------------------------------------------------------------------------
// A pixel's first result word leaves via the s1, s2 and emitter registers. One
// pixel is accepted per cycle while each pixel causes at most one word and the
// port is ready; a pixel causing two or three words stalls the input until its
// last word is taken. Reset clears the row and column counters and the window
// and loads width 640 and height 480; line stores are not cleared and need not be.
module rgb_box_filter_3x3 (
  input  logic      clk,
  input  logic      rst,
  bf3_pix_if.sink   pixels,
  bf3_res_if.source results,
  bf3_cfg_if.sink   cfg
);

  logic [bf3_pkg::DIM_W-1:0] frame_width;
  logic [bf3_pkg::DIM_W-1:0] frame_height;
  logic [bf3_pkg::DIM_W-1:0] w_eff;
  logic [bf3_pkg::DIM_W-1:0] h_eff;
  logic [bf3_pkg::DIM_W-1:0] w_less;
  logic [bf3_pkg::DIM_W-1:0] h_less;
  logic [bf3_pkg::COL_W-1:0] last_col_idx;
  logic [bf3_pkg::ROW_W-1:0] last_row_idx;

  logic [bf3_pkg::COL_W-1:0] col_count;
  logic [bf3_pkg::ROW_W-1:0] row_count;
  logic [bf3_pkg::COL_W-1:0] cur_col;
  logic [bf3_pkg::ROW_W-1:0] cur_row;
  logic                      is_last_col;
  logic                      is_last_row;
  logic [bf3_pkg::PIX_W-1:0] in_px;
  logic                      in_accept;

  logic                      s1_valid;
  bf3_pkg::bf3_item_t        s1_item;
  logic                      s1_move;
  logic                      s2_valid;
  bf3_pkg::bf3_item_t        s2_item;
  bf3_pkg::bf3_view_t        s2_view;
  logic                      s2_ready;
  logic                      s1_ready;

  logic [2*bf3_pkg::PIX_W-1:0] ram_rdata;
  bf3_pkg::bf3_view_t          win_view;

  logic [bf3_pkg::PROD_W-1:0]                  prod [3];
  logic [bf3_pkg::PIX_W-1:0]                   mean;
  logic [bf3_pkg::ROW_W-1:0]                   row_m1;
  logic [bf3_pkg::COL_W-1:0]                   col_m1;
  logic                                        border;
  logic [bf3_pkg::NUM_RES-1:0]                 s2_mask;
  bf3_pkg::bf3_result_t [bf3_pkg::NUM_RES-1:0] s2_res;
  logic                                        emit_free;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bf3_pkg::WIDTH_RESET;
      frame_height <= bf3_pkg::HEIGHT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        bf3_pkg::REG_FRAME_WIDTH: begin
          frame_width <= cfg.data;
        end
        bf3_pkg::REG_FRAME_HEIGHT: begin
          frame_height <= cfg.data;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (frame_width < bf3_pkg::DIM_W'(bf3_pkg::MIN_DIM)) begin
      w_eff = bf3_pkg::DIM_W'(bf3_pkg::MIN_DIM);
    end else if (frame_width > bf3_pkg::DIM_W'(bf3_pkg::MAX_WIDTH)) begin
      w_eff = bf3_pkg::DIM_W'(bf3_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height < bf3_pkg::DIM_W'(bf3_pkg::MIN_DIM)) begin
      h_eff = bf3_pkg::DIM_W'(bf3_pkg::MIN_DIM);
    end else if (frame_height > bf3_pkg::DIM_W'(bf3_pkg::MAX_HEIGHT)) begin
      h_eff = bf3_pkg::DIM_W'(bf3_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  assign w_less       = w_eff - bf3_pkg::DIM_W'(1);
  assign h_less       = h_eff - bf3_pkg::DIM_W'(1);
  assign last_col_idx = w_less[bf3_pkg::COL_W-1:0];
  assign last_row_idx = h_less[bf3_pkg::ROW_W-1:0];

  // Input stage: position of the incoming pixel, saturated to the frame.
  assign cur_col     = (col_count > last_col_idx) ? last_col_idx : col_count;
  assign cur_row     = (row_count > last_row_idx) ? last_row_idx : row_count;
  assign is_last_col = cur_col == last_col_idx;
  assign is_last_row = cur_row == last_row_idx;
  assign in_px       = {pixels.blue_in, pixels.green_in, pixels.red_in};

  assign s2_ready     = !s2_valid || emit_free;
  assign s1_ready     = !s1_valid || s2_ready;
  assign s1_move      = s1_valid && s2_ready;
  assign pixels.ready = s1_ready;
  assign in_accept    = pixels.valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_accept) begin
      if (is_last_col) begin
        col_count <= '0;
        row_count <= is_last_row ? '0 : cur_row + bf3_pkg::ROW_W'(1);
      end else begin
        col_count <= cur_col + bf3_pkg::COL_W'(1);
        row_count <= cur_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item.px       <= in_px;
      s1_item.row      <= cur_row;
      s1_item.col      <= cur_col;
      s1_item.last_col <= is_last_col;
      s1_item.last_row <= is_last_row;
    end
  end

  // Both line stores share one word per column: older line high, newer low.
  bf3_ram #(
    .WIDTH (2 * bf3_pkg::PIX_W),
    .DEPTH (bf3_pkg::MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_item.col),
    .wdata ({ram_rdata[bf3_pkg::PIX_W-1:0], s1_item.px}),
    .re    (in_accept),
    .raddr (cur_col),
    .rdata (ram_rdata)
  );

  bf3_window u_window (
    .clk   (clk),
    .rst   (rst),
    .shift (s1_move),
    .older (ram_rdata[bf3_pkg::PIX_W +: bf3_pkg::PIX_W]),
    .newer (ram_rdata[bf3_pkg::PIX_W-1:0]),
    .px    (s1_item.px),
    .view  (win_view)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_item <= s1_item;
      s2_view <= win_view;
    end
  end

  // Divide stage and assembly of the result group.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = bf3_pkg::PROD_W'(s2_view.sum[ch]) * bf3_pkg::PROD_W'(bf3_pkg::RECIP9);
      mean[ch*bf3_pkg::CH_W +: bf3_pkg::CH_W] = prod[ch][bf3_pkg::DIV_SHIFT +: bf3_pkg::CH_W];
    end
  end

  assign row_m1 = s2_item.row - bf3_pkg::ROW_W'(1);
  assign col_m1 = s2_item.col - bf3_pkg::COL_W'(1);
  assign border = (s2_item.row == bf3_pkg::ROW_W'(1)) || (s2_item.col == bf3_pkg::COL_W'(1));

  assign s2_mask[0] = (s2_item.row != '0) && (s2_item.col != '0);
  assign s2_mask[1] = (s2_item.row != '0) && s2_item.last_col;
  assign s2_mask[2] = s2_item.last_row;

  assign s2_res[0].px   = border ? s2_view.center : mean;
  assign s2_res[0].row  = row_m1;
  assign s2_res[0].col  = col_m1;
  assign s2_res[0].done = 1'b0;
  assign s2_res[1].px   = s2_view.right_mid;
  assign s2_res[1].row  = row_m1;
  assign s2_res[1].col  = s2_item.col;
  assign s2_res[1].done = 1'b0;
  assign s2_res[2].px   = s2_item.px;
  assign s2_res[2].row  = s2_item.row;
  assign s2_res[2].col  = s2_item.col;
  assign s2_res[2].done = s2_item.last_col;

  bf3_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_valid),
    .in_mask  (s2_mask),
    .in_res   (s2_res),
    .free     (emit_free),
    .results  (results)
  );

`ifndef NO_ASSERTIONS
  a_done_is_last : assert property (@(posedge clk) disable iff (rst)
    results.valid && results.frame_done |-> results.run_last)
    else $error("frame_done word not marked as last of its group");

  a_accept_loads_s1 : assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s1_valid &&
      s1_item.px == $past({pixels.blue_in, pixels.green_in, pixels.red_in}))
    else $error("accepted pixel did not reach the first stage");

  a_s1_holds : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid && $stable(s1_item))
    else $error("first stage lost its pixel while stalled");
`endif

endmodule
